@@ src/tcf_pkg.sv @@
// Shared types, constants and the arctangent table of the tilt complementary filter.
`default_nettype none

package tcf_pkg;

    localparam int CORDIC_STEPS_DEF    = 16;
    localparam int ANGLE_FRAC_BITS_DEF = 7;

    localparam int SAMPLE_W   = 16;
    localparam int S_TDATA_W  = 3 * SAMPLE_W;
    localparam int M_TDATA_W  = 2 * SAMPLE_W;

    // Configuration port
    localparam int CFG_ADDR_W = 2;
    localparam int CFG_DATA_W = 32;

    localparam logic [CFG_ADDR_W-1:0] CFG_BLEND_WEIGHT   = 2'd0;
    localparam logic [CFG_ADDR_W-1:0] CFG_GYRO_STEP_GAIN = 2'd1;
    localparam logic [CFG_ADDR_W-1:0] CFG_ACCEL_Y_OFFSET = 2'd2;
    localparam logic [CFG_ADDR_W-1:0] CFG_ACCEL_Z_OFFSET = 2'd3;

    localparam logic [15:0] BLEND_WEIGHT_RST   = 16'd58982;
    localparam logic [31:0] GYRO_STEP_GAIN_RST = 32'd655348;

    // CORDIC datapath widths; angles carried in 2^-16 degree
    localparam int CORDIC_W    = 28;
    localparam int ANG_W       = 28;
    localparam int ATAN_W      = 22;
    localparam int ATAN_TAB_LEN = 24;
    localparam int TAB_IDX_W   = 5;
    localparam int DEG_90      = 5898240;
    localparam int DEG_180     = 11796480;

    // Shared multiplier: 17-bit signed by 33-bit signed
    localparam int MUL_A_W = 17;
    localparam int MUL_B_W = 33;
    localparam int PROD_W  = MUL_A_W + MUL_B_W;

    typedef struct packed {
        logic                 load;
        logic                 init;
        logic                 pred;
        logic                 rot;
        logic                 acc;
        logic                 diff;
        logic                 mul_lo;
        logic                 mul_hi;
        logic                 fin;
        logic [TAB_IDX_W-1:0] step;
    } cmd_t;

    // atan(2^-i) in 2^-16 degree, rounded
    function automatic logic [ATAN_W-1:0] atan_lut(input logic [TAB_IDX_W-1:0] idx);
        logic [ATAN_W-1:0] v;
        case (idx)
            5'd0:    v = 22'd2949120;
            5'd1:    v = 22'd1740967;
            5'd2:    v = 22'd919879;
            5'd3:    v = 22'd466945;
            5'd4:    v = 22'd234379;
            5'd5:    v = 22'd117304;
            5'd6:    v = 22'd58666;
            5'd7:    v = 22'd29335;
            5'd8:    v = 22'd14668;
            5'd9:    v = 22'd7334;
            5'd10:   v = 22'd3667;
            5'd11:   v = 22'd1833;
            5'd12:   v = 22'd917;
            5'd13:   v = 22'd458;
            5'd14:   v = 22'd229;
            5'd15:   v = 22'd115;
            5'd16:   v = 22'd57;
            5'd17:   v = 22'd29;
            5'd18:   v = 22'd14;
            5'd19:   v = 22'd7;
            5'd20:   v = 22'd4;
            5'd21:   v = 22'd2;
            5'd22:   v = 22'd1;
            default: v = 22'd0;
        endcase
        return v;
    endfunction

endpackage

`default_nettype wire

@@ src/tcf_datapath.sv @@
// Datapath of the tilt complementary filter: config registers, CORDIC, multiplier, blend.
`default_nettype none

module tcf_datapath #(
    parameter int ANGLE_FRAC_BITS = tcf_pkg::ANGLE_FRAC_BITS_DEF
) (
    input  wire logic                                aclk,
    input  wire logic                                aresetn,
    input  wire tcf_pkg::cmd_t                       cmd,
    input  wire logic signed [tcf_pkg::SAMPLE_W-1:0] accel_y,
    input  wire logic signed [tcf_pkg::SAMPLE_W-1:0] accel_z,
    input  wire logic signed [tcf_pkg::SAMPLE_W-1:0] gyro_x,
    input  wire logic                                cfg_wr_en,
    input  wire logic [tcf_pkg::CFG_ADDR_W-1:0]      cfg_addr,
    input  wire logic [tcf_pkg::CFG_DATA_W-1:0]      cfg_wdata,
    output logic signed [tcf_pkg::SAMPLE_W-1:0]      fused_angle,
    output logic signed [tcf_pkg::SAMPLE_W-1:0]      accel_angle
);

    localparam int CW     = tcf_pkg::CORDIC_W;
    localparam int ZW     = tcf_pkg::ANG_W;
    localparam int PROD_W = tcf_pkg::PROD_W;
    localparam int PRED_W = ANGLE_FRAC_BITS + 34;
    localparam int HI_W   = PRED_W - 16;
    localparam int INC_W  = PROD_W + ANGLE_FRAC_BITS;
    localparam int R_W    = PROD_W - 16;
    localparam int DROP   = 16 - ANGLE_FRAC_BITS;

    localparam logic signed [ZW-1:0]    DEG90_Z  = ZW'(tcf_pkg::DEG_90);
    localparam logic signed [ZW-1:0]    DEG180_P = ZW'(tcf_pkg::DEG_180);
    localparam logic signed [ZW-1:0]    DEG180_N = ZW'(-tcf_pkg::DEG_180);
    localparam logic signed [ZW-1:0]    T_RND    = ZW'(1 << (DROP - 1));
    localparam logic signed [ZW-1:0]    T_MAX    = ZW'(32767);
    localparam logic signed [ZW-1:0]    T_MIN    = ZW'(-32768);
    localparam logic signed [INC_W-1:0] INC_RND  = INC_W'(32768);
    localparam logic signed [R_W-1:0]   F_MAX    = R_W'(32767);
    localparam logic signed [R_W-1:0]   F_MIN    = R_W'(-32768);

    // Configuration and filter state
    logic [15:0]        blend_weight_reg;
    logic [31:0]        gyro_gain_reg;
    logic [15:0]        y_offset_reg;
    logic [15:0]        z_offset_reg;
    logic signed [15:0] angle_est_reg;

    // Working registers
    logic signed [15:0]       ay_reg, az_reg, gx_reg;
    logic                     swap_reg, zero_reg;
    logic signed [CW-1:0]     cx_reg, cy_reg;
    logic signed [ZW-1:0]     cz_reg;
    logic signed [PROD_W-1:0] prod_reg;
    logic signed [PRED_W-1:0] pred_reg;
    logic signed [15:0]       acc_reg;
    logic [16:0]              lo_rnd_reg;
    logic signed [15:0]       fused_out_reg, accel_out_reg;

    // Next values
    logic signed [15:0]       ay_next, az_next;
    logic                     swap_next, zero_next;
    logic signed [15:0]       op_a, op_b;
    logic signed [CW-1:0]     x_scl, y_scl;
    logic signed [CW-1:0]     cx_init_next, cy_init_next;
    logic signed [ZW-1:0]     cz_init_next;
    logic signed [CW-1:0]     dx, dy;
    logic                     rot_neg;
    logic signed [ZW-1:0]     tab_ext;
    logic signed [CW-1:0]     cx_rot_next, cy_rot_next;
    logic signed [ZW-1:0]     cz_rot_next;
    logic signed [INC_W-1:0]  inc_full, inc_rnd;
    logic signed [PRED_W-1:0] est_ext, pred_next, diff_next, acc_shift;
    logic signed [ZW-1:0]     z_eff, t_ang, t_rnd, t_sh;
    logic signed [15:0]       acc_next;
    logic [32:0]              lo_sum;
    logic [16:0]              lo_rnd_next;
    logic signed [PROD_W-1:0] fin_sum;
    logic signed [R_W-1:0]    fin_r, acc_r, fused_raw;
    logic signed [15:0]       fused_next;
    logic signed [tcf_pkg::MUL_A_W-1:0] mul_a;
    logic signed [tcf_pkg::MUL_B_W-1:0] mul_b;
    logic signed [PROD_W-1:0]           mul_p;

    // Offsets wrap at 16 bits
    assign ay_next = accel_y + signed'(y_offset_reg);
    assign az_next = accel_z + signed'(z_offset_reg);

    // CORDIC preset: pick operand order, scale by 256, fold left half-plane
    always_comb begin
        swap_next = !(!ay_reg[15] && (ay_reg != 16'sd0));
        op_a      = swap_next ? az_reg : ay_reg;
        op_b      = swap_next ? ay_reg : az_reg;
        zero_next = (op_a == 16'sd0) && (op_b == 16'sd0);
        x_scl     = {{(CW-24){op_b[15]}}, op_b, 8'd0};
        y_scl     = {{(CW-24){op_a[15]}}, op_a, 8'd0};
        if (op_b[15]) begin
            cx_init_next = -x_scl;
            cy_init_next = -y_scl;
            cz_init_next = op_a[15] ? DEG180_N : DEG180_P;
        end else begin
            cx_init_next = x_scl;
            cy_init_next = y_scl;
            cz_init_next = '0;
        end
    end

    // One vectoring step per cycle
    always_comb begin
        dx      = cy_reg >>> cmd.step;
        dy      = cx_reg >>> cmd.step;
        rot_neg = !cy_reg[CW-1] && (cy_reg != '0);
        tab_ext = $signed({{(ZW-tcf_pkg::ATAN_W){1'b0}}, tcf_pkg::atan_lut(cmd.step)});
        if (rot_neg) begin
            cx_rot_next = cx_reg + dx;
            cy_rot_next = cy_reg - dy;
            cz_rot_next = cz_reg + tab_ext;
        end else begin
            cx_rot_next = cx_reg - dx;
            cy_rot_next = cy_reg + dy;
            cz_rot_next = cz_reg - tab_ext;
        end
    end

    // Gyro prediction: round the scaled increment, add the stored angle
    always_comb begin
        inc_full  = $signed({prod_reg, {ANGLE_FRAC_BITS{1'b0}}});
        inc_rnd   = inc_full + INC_RND;
        est_ext   = $signed({{(PRED_W-32){angle_est_reg[15]}}, angle_est_reg, 16'd0});
        pred_next = est_ext + $signed(inc_rnd[INC_W-1:16]);
        acc_shift = $signed({{(PRED_W-32){acc_reg[15]}}, acc_reg, 16'd0});
        diff_next = pred_reg - acc_shift;
    end

    // Accelerometer tilt: undo the swap, round to output scale, saturate
    always_comb begin
        z_eff = zero_reg ? '0 : cz_reg;
        t_ang = swap_reg ? (DEG90_Z - z_eff) : z_eff;
        t_rnd = t_ang + T_RND;
        t_sh  = t_rnd >>> DROP;
        if (t_sh > T_MAX) begin
            acc_next = 16'sh7FFF;
        end else if (t_sh < T_MIN) begin
            acc_next = -16'sh8000;
        end else begin
            acc_next = t_sh[15:0];
        end
    end

    // Shared multiplier: gyro gain, then alpha times the low and high halves of the difference
    always_comb begin
        if (cmd.init) begin
            mul_a = {gx_reg[15], gx_reg};
            mul_b = {1'b0, gyro_gain_reg};
        end else begin
            mul_a = {1'b0, blend_weight_reg};
            if (cmd.mul_hi) begin
                mul_b = {{(tcf_pkg::MUL_B_W-HI_W){pred_reg[PRED_W-1]}}, pred_reg[PRED_W-1:16]};
            end else begin
                mul_b = {{(tcf_pkg::MUL_B_W-16){1'b0}}, pred_reg[15:0]};
            end
        end
    end

    assign mul_p = mul_a * mul_b;

    // Blend: fused = acc + round(alpha * (pred - acc * 2^16) / 2^32)
    always_comb begin
        lo_sum      = {1'b0, prod_reg[31:0]} + 33'h0_8000_0000;
        lo_rnd_next = lo_sum[32:16];
        fin_sum     = prod_reg + $signed({{(PROD_W-17){1'b0}}, lo_rnd_reg});
        fin_r       = $signed(fin_sum[PROD_W-1:16]);
        acc_r       = $signed({{(R_W-16){acc_reg[15]}}, acc_reg});
        fused_raw   = fin_r + acc_r;
        if (fused_raw > F_MAX) begin
            fused_next = 16'sh7FFF;
        end else if (fused_raw < F_MIN) begin
            fused_next = -16'sh8000;
        end else begin
            fused_next = fused_raw[15:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            blend_weight_reg <= tcf_pkg::BLEND_WEIGHT_RST;
            gyro_gain_reg    <= tcf_pkg::GYRO_STEP_GAIN_RST;
            y_offset_reg     <= '0;
            z_offset_reg     <= '0;
            angle_est_reg    <= '0;
        end else begin
            if (cfg_wr_en) begin
                case (cfg_addr)
                    tcf_pkg::CFG_BLEND_WEIGHT:   blend_weight_reg <= cfg_wdata[15:0];
                    tcf_pkg::CFG_GYRO_STEP_GAIN: gyro_gain_reg    <= cfg_wdata[31:0];
                    tcf_pkg::CFG_ACCEL_Y_OFFSET: y_offset_reg     <= cfg_wdata[15:0];
                    tcf_pkg::CFG_ACCEL_Z_OFFSET: z_offset_reg     <= cfg_wdata[15:0];
                    default: ;
                endcase
            end
            if (cmd.fin) begin
                angle_est_reg <= fused_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            ay_reg <= ay_next;
            az_reg <= az_next;
            gx_reg <= gyro_x;
        end
        if (cmd.init) begin
            swap_reg <= swap_next;
            zero_reg <= zero_next;
            cx_reg   <= cx_init_next;
            cy_reg   <= cy_init_next;
            cz_reg   <= cz_init_next;
        end
        if (cmd.rot) begin
            cx_reg <= cx_rot_next;
            cy_reg <= cy_rot_next;
            cz_reg <= cz_rot_next;
        end
        if (cmd.init || cmd.mul_lo || cmd.mul_hi) begin
            prod_reg <= mul_p;
        end
        if (cmd.pred) begin
            pred_reg <= pred_next;
        end
        if (cmd.diff) begin
            pred_reg <= diff_next;
        end
        if (cmd.acc) begin
            acc_reg <= acc_next;
        end
        if (cmd.mul_hi) begin
            lo_rnd_reg <= lo_rnd_next;
        end
        if (cmd.fin) begin
            fused_out_reg <= fused_next;
            accel_out_reg <= acc_reg;
        end
    end

    assign fused_angle = fused_out_reg;
    assign accel_angle = accel_out_reg;

endmodule

`default_nettype wire

@@ src/tcf_ctrl.sv @@
// Controller of the tilt complementary filter: sequences the datapath and owns the handshakes.
`default_nettype none

module tcf_ctrl #(
    parameter int CORDIC_STEPS = tcf_pkg::CORDIC_STEPS_DEF
) (
    input  wire logic    aclk,
    input  wire logic    aresetn,
    input  wire logic    s_tvalid,
    output logic         s_tready,
    output logic         m_tvalid,
    input  wire logic    m_tready,
    output tcf_pkg::cmd_t cmd
);

    localparam int NSTEPS = (CORDIC_STEPS < tcf_pkg::ATAN_TAB_LEN) ?
                            CORDIC_STEPS : tcf_pkg::ATAN_TAB_LEN;
    localparam int STEP_W = $clog2(NSTEPS);
    localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(NSTEPS - 1);

    typedef enum logic [3:0] {
        S_IDLE,
        S_INIT,
        S_PRED,
        S_ROT,
        S_ACC,
        S_DIFF,
        S_MLO,
        S_MHI,
        S_FIN
    } state_t;

    state_t            state_reg, state_next;
    logic [STEP_W-1:0] cnt_reg, cnt_next;
    logic              s_tready_reg, s_tready_next;
    logic              m_tvalid_reg, m_tvalid_next;

    always_comb begin
        state_next    = state_reg;
        cnt_next      = cnt_reg;
        m_tvalid_next = m_tvalid_reg && !m_tready;
        cmd           = '0;
        cmd.step      = tcf_pkg::TAB_IDX_W'(cnt_reg);
        case (state_reg)
            S_IDLE: begin
                if (s_tvalid && s_tready_reg) begin
                    cmd.load   = 1'b1;
                    state_next = S_INIT;
                end
            end
            S_INIT: begin
                cmd.init   = 1'b1;
                state_next = S_PRED;
            end
            S_PRED: begin
                cmd.pred   = 1'b1;
                state_next = S_ROT;
            end
            S_ROT: begin
                cmd.rot = 1'b1;
                if (cnt_reg == LAST_STEP) begin
                    cnt_next   = '0;
                    state_next = S_ACC;
                end else begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            S_ACC: begin
                cmd.acc    = 1'b1;
                state_next = S_DIFF;
            end
            S_DIFF: begin
                cmd.diff   = 1'b1;
                state_next = S_MLO;
            end
            S_MLO: begin
                cmd.mul_lo = 1'b1;
                state_next = S_MHI;
            end
            S_MHI: begin
                cmd.mul_hi = 1'b1;
                state_next = S_FIN;
            end
            S_FIN: begin
                // hold until the output register is free
                if (!m_tvalid_reg || m_tready) begin
                    cmd.fin       = 1'b1;
                    m_tvalid_next = 1'b1;
                    state_next    = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
        s_tready_next = (state_next == S_IDLE);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            cnt_reg      <= '0;
            s_tready_reg <= 1'b1;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            cnt_reg      <= cnt_next;
            s_tready_reg <= s_tready_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    assign s_tready = s_tready_reg;
    assign m_tvalid = m_tvalid_reg;

endmodule

`default_nettype wire

@@ src/tilt_complementary_filter.sv @@
// Top level of the tilt complementary filter: controller plus datapath.
//
// Usage:
//   Input stream s_*: one transfer per sample set (accel Y, accel Z, gyro X).
//   Output stream m_*: one transfer per sample set (fused angle, accel angle),
//   both signed, in 1/2^ANGLE_FRAC_BITS degree.
//   Configuration: cfg_wr_en writes cfg_wdata into register cfg_addr
//   (0 blend weight, 1 gyro step gain, 2 accel Y offset, 3 accel Z offset);
//   write only while no sample is in flight.
// Sequencing (N = CORDIC_STEPS, capped at 24):
//   after the input transfer a sample passes INIT, PRED, N ROT steps, ACC,
//   DIFF, MLO, MHI and FIN, which sets m_tvalid; no new sample is taken before
//   that. The iterative CORDIC dominates, one vectoring step per cycle,
//   followed by two passes through the shared 17x33 multiplier for the blend.
// Reset: aresetn (synchronous, active low) restores the register defaults,
//   clears the stored angle and empties the output register.
// Backpressure: a finished result sits in the output register until m_tready;
//   the next sample is still accepted meanwhile, and its computation waits in
//   the final step only if the previous result has not yet been taken.
`default_nettype none

module tilt_complementary_filter #(
    parameter int CORDIC_STEPS    = tcf_pkg::CORDIC_STEPS_DEF,
    parameter int ANGLE_FRAC_BITS = tcf_pkg::ANGLE_FRAC_BITS_DEF
) (
    input  wire logic                             aclk,
    input  wire logic                             aresetn,
    // input stream
    input  wire logic                             s_tvalid,
    output logic                                  s_tready,
    input  wire logic [tcf_pkg::S_TDATA_W-1:0]    s_tdata,   // accel_y, accel_z, gyro_x
    // result stream
    output logic                                  m_tvalid,
    input  wire logic                             m_tready,
    output logic [tcf_pkg::M_TDATA_W-1:0]         m_tdata,   // fused_angle, accel_angle
    // configuration writes
    input  wire logic                             cfg_wr_en,
    input  wire logic [tcf_pkg::CFG_ADDR_W-1:0]   cfg_addr,
    input  wire logic [tcf_pkg::CFG_DATA_W-1:0]   cfg_wdata
);

    tcf_pkg::cmd_t                      cmd;
    logic signed [tcf_pkg::SAMPLE_W-1:0] fused_angle;
    logic signed [tcf_pkg::SAMPLE_W-1:0] accel_angle;

    // sequence the sample through the datapath
    tcf_ctrl #(
        .CORDIC_STEPS (CORDIC_STEPS)
    ) u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .cmd      (cmd)
    );

    // unpack the sample set, lowest field first
    tcf_datapath #(
        .ANGLE_FRAC_BITS (ANGLE_FRAC_BITS)
    ) u_datapath (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cmd         (cmd),
        .accel_y     (s_tdata[15:0]),
        .accel_z     (s_tdata[31:16]),
        .gyro_x      (s_tdata[47:32]),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_addr    (cfg_addr),
        .cfg_wdata   (cfg_wdata),
        .fused_angle (fused_angle),
        .accel_angle (accel_angle)
    );

    // pack the result, fused angle in the low half
    assign m_tdata = {accel_angle, fused_angle};

endmodule

`default_nettype wire

@@ src/tcf_checker.sv @@
// Port-level assertions of the tilt complementary filter, bound to the top level.
`default_nettype none

module tcf_checker (
    input wire logic                          aclk,
    input wire logic                          aresetn,
    input wire logic                          s_tvalid,
    input wire logic                          s_tready,
    input wire logic                          m_tvalid,
    input wire logic                          m_tready,
    input wire logic [tcf_pkg::M_TDATA_W-1:0] m_tdata
);

    // output register is empty after reset
    assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("m_tvalid not cleared by reset");

    // a stalled result holds
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("stalled result changed");

    // one sample at a time: no second transfer right after an accepted one
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input accepted back to back");

    // a result never appears in the cycle after an input transfer
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !$rose(m_tvalid))
        else $error("result too early after input transfer");

    // a new result is produced only while the input side is busy
    assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) |-> !$past(s_tready))
        else $error("result produced while idle");

endmodule

bind tilt_complementary_filter tcf_checker u_tcf_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

`default_nettype wire

@@ test/tilt_complementary_filter_tb.sv @@
// Self-checking testbench of tilt_complementary_filter: directed and random samples against a predictor.
module tilt_complementary_filter_tb;

    // Vectoring steps of the prediction, capped at the table length
    localparam int VEC_STEPS = (tcf_pkg::CORDIC_STEPS_DEF < 24) ? tcf_pkg::CORDIC_STEPS_DEF : 24;
    localparam int DROP_BITS = 16 - tcf_pkg::ANGLE_FRAC_BITS_DEF;
    localparam int PHASES = 8;
    localparam int PHASE_ITEMS = 200;
    localparam int END_CYCLES = 40;
    localparam int LIMIT_TIME = 4000000;

    // atan(2^-i) in 2^-16 degree
    localparam longint ATAN_STEP [0:23] = '{
        2949120, 1740967, 919879, 466945, 234379, 117304, 58666, 29335,
        14668, 7334, 3667, 1833, 917, 458, 229, 115,
        57, 29, 14, 7, 4, 2, 1, 0
    };

    typedef struct packed {
        logic [15:0] fused;
        logic [15:0] tilt;
    } angle_pair_t;

    // Predicts the filter outputs sample by sample and holds them until the DUT
    // delivers the matching transfer.
    class angle_scoreboard;
        logic [15:0] blend_weight;
        logic [31:0] gyro_gain;
        logic [15:0] y_offset;
        logic [15:0] z_offset;
        logic signed [15:0] angle_est;
        angle_pair_t expected_angles[$];
        int errors;

        function new();
            blend_weight = tcf_pkg::BLEND_WEIGHT_RST;
            gyro_gain = tcf_pkg::GYRO_STEP_GAIN_RST;
            y_offset = '0;
            z_offset = '0;
            angle_est = '0;
            errors = 0;
        endfunction

        function void write_reg(logic [tcf_pkg::CFG_ADDR_W-1:0] idx,
                                logic [tcf_pkg::CFG_DATA_W-1:0] val);
            case (idx)
                tcf_pkg::CFG_BLEND_WEIGHT:   blend_weight = val[15:0];
                tcf_pkg::CFG_GYRO_STEP_GAIN: gyro_gain = val;
                tcf_pkg::CFG_ACCEL_Y_OFFSET: y_offset = val[15:0];
                tcf_pkg::CFG_ACCEL_Z_OFFSET: z_offset = val[15:0];
                default: ;
            endcase
        endfunction

        function int pending();
            return expected_angles.size();
        endfunction

        function logic signed [15:0] clamp16(longint v);
            if (v > 32767)
                return 16'sh7FFF;
            if (v < -32768)
                return 16'sh8000;
            return v[15:0];
        endfunction

        // Angle of the vector (x = b, y = a) in 2^-16 degree
        function longint vector_angle(longint a, longint b);
            longint x, y, z, dx, dy;
            x = b * 256;
            y = a * 256;
            z = 0;
            if (x == 0 && y == 0)
                return 0;
            // fold the left half plane over, presetting half a turn
            if (x < 0) begin
                z = (y >= 0) ? 180 * 65536 : -180 * 65536;
                x = -x;
                y = -y;
            end
            for (int i = 0; i < VEC_STEPS; i++) begin
                dx = y >>> i;
                dy = x >>> i;
                if (y > 0) begin
                    x += dx;
                    y -= dy;
                    z += ATAN_STEP[i];
                end else begin
                    x -= dx;
                    y += dy;
                    z -= ATAN_STEP[i];
                end
            end
            return z;
        endfunction

        function void predict_angles(logic [15:0] ay, logic [15:0] az, logic [15:0] gx);
            logic [15:0] ys, zs;
            longint y, z, g, t, gain, inc, pred, alpha, tilt_l, num;
            angle_pair_t e;
            ys = ay + y_offset;
            zs = az + z_offset;
            y = $signed(ys);
            z = $signed(zs);
            g = $signed(gx);
            if (y > 0)
                t = vector_angle(y, z);
            else
                t = longint'(90 * 65536) - vector_angle(z, y);
            e.tilt = clamp16((t + (longint'(1) <<< (DROP_BITS - 1))) >>> DROP_BITS);
            gain = $signed({32'd0, gyro_gain});
            inc = g * gain * (longint'(1) <<< tcf_pkg::ANGLE_FRAC_BITS_DEF);
            inc = (inc + 32768) >>> 16;
            pred = longint'(angle_est) * 65536 + inc;
            alpha = $signed({48'd0, blend_weight});
            tilt_l = $signed(e.tilt);
            num = alpha * pred + (65536 - alpha) * (tilt_l * 65536);
            e.fused = clamp16((num + (longint'(1) <<< 31)) >>> 32);
            angle_est = e.fused;
            expected_angles.push_back(e);
        endfunction

        function void check_result(logic [15:0] fused, logic [15:0] tilt);
            angle_pair_t e;
            if (expected_angles.size() == 0) begin
                $display("%0t: unexpected result fused %0d tilt %0d", $time,
                         $signed(fused), $signed(tilt));
                errors++;
                return;
            end
            e = expected_angles.pop_front();
            if (fused !== e.fused) begin
                $display("%0t: fused_angle expected %0d actual %0d", $time,
                         $signed(e.fused), $signed(fused));
                errors++;
            end
            if (tilt !== e.tilt) begin
                $display("%0t: accel_angle expected %0d actual %0d", $time,
                         $signed(e.tilt), $signed(tilt));
                errors++;
            end
        endfunction
    endclass

    logic                           aclk = 1'b0;
    logic                           aresetn = 1'b0;
    logic                           s_tvalid = 1'b0;
    logic                           s_tready;
    logic [tcf_pkg::S_TDATA_W-1:0]  s_tdata = '0;    // accel_y, accel_z, gyro_x
    logic                           m_tvalid;
    logic                           m_tready = 1'b0;
    logic [tcf_pkg::M_TDATA_W-1:0]  m_tdata;         // fused_angle, accel_angle
    logic                           cfg_wr_en = 1'b0;
    logic [tcf_pkg::CFG_ADDR_W-1:0] cfg_addr = '0;
    logic [tcf_pkg::CFG_DATA_W-1:0] cfg_wdata = '0;

    // Idle rates in percent; the stimulus changes them per phase
    int send_idle = 15;
    int recv_idle = 69;

    angle_scoreboard sb;

    tilt_complementary_filter DUT (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_wr_en (cfg_wr_en),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata)
    );

    initial begin
        forever #4 aclk = ~aclk;
    end

    // Watchdog: a correct run finishes far sooner
    initial begin
        #LIMIT_TIME;
        $display("CHECK FAILED");
        $finish;
    end

    // Result side: check every transfer, then pick the next ready at random.
    // Values read here are the ones from before the edge, so no race with the DUT.
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready)
            sb.check_result(m_tdata[15:0], m_tdata[31:16]);
        m_tready <= ($urandom_range(99) >= recv_idle);
    end

    // Offer one sample set, idling first at the sender rate; predict it once
    // the transfer happens. Valid stays high when the next call sends at once.
    task automatic push_sample(input logic [15:0] ay, input logic [15:0] az,
                               input logic [15:0] gx);
        while ($urandom_range(99) < send_idle) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= {gx, az, ay};
        do @(posedge aclk); while (!s_tready);
        sb.predict_angles(ay, az, gx);
    endtask

    // Hold the input and wait until every predicted result has come back
    task automatic drain();
        s_tvalid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge aclk);
    endtask

    // Leave the enable high between writes; the caller drops it after the last one
    task automatic put_reg(input logic [tcf_pkg::CFG_ADDR_W-1:0] idx,
                           input logic [tcf_pkg::CFG_DATA_W-1:0] val);
        cfg_wr_en <= 1'b1;
        cfg_addr <= idx;
        cfg_wdata <= val;
        @(posedge aclk);
        sb.write_reg(idx, val);
    endtask

    // Write all four registers; upper bits of the 16-bit ones carry junk that must be ignored
    task automatic program_regs(input logic [15:0] bw, input logic [31:0] gain,
                                input logic [15:0] yoff, input logic [15:0] zoff);
        put_reg(tcf_pkg::CFG_BLEND_WEIGHT, {16'($urandom), bw});
        put_reg(tcf_pkg::CFG_GYRO_STEP_GAIN, gain);
        put_reg(tcf_pkg::CFG_ACCEL_Y_OFFSET, {16'($urandom), yoff});
        put_reg(tcf_pkg::CFG_ACCEL_Z_OFFSET, {16'($urandom), zoff});
        cfg_wr_en <= 1'b0;
    endtask

    initial begin : stimulus
        logic [15:0] bw, yo, zo, ay, az, gx;
        logic [31:0] gain;
        int kind;

        sb = new();
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed part at the reset register values
        push_sample(16'h0000, 16'h0000, 16'h0000);     // zero vector: 90 degrees
        push_sample(16'h7FFF, 16'h0000, 16'h0000);
        push_sample(16'h8000, 16'h0000, 16'h0000);
        push_sample(16'h0000, 16'h7FFF, 16'h0000);
        push_sample(16'h0000, 16'h8000, 16'h0000);     // y zero, z negative
        push_sample(16'h7FFF, 16'h7FFF, 16'h7FFF);
        push_sample(16'h8000, 16'h8000, 16'h8000);
        push_sample(16'h7FFF, 16'h8000, 16'hFFFF);
        push_sample(16'h8000, 16'h7FFF, 16'h0001);
        push_sample(16'h8000, 16'hFFFF, 16'h0000);     // tilt near 270: saturates
        push_sample(16'hFFFF, 16'h8000, 16'h0000);
        push_sample(16'hFF9C, 16'hFFFF, 16'h0000);
        push_sample(16'h0001, 16'h0001, 16'h0000);
        push_sample(16'h0001, 16'hFFFF, 16'h0000);
        push_sample(16'hFFFF, 16'h0001, 16'h0000);
        push_sample(16'hFFFF, 16'hFFFF, 16'h0000);
        push_sample(16'h0000, 16'h0064, 16'h7FFF);
        push_sample(16'h0000, 16'h0064, 16'h8000);
        push_sample(16'h1388, 16'h1388, 16'h3039);
        push_sample(16'h0000, 16'hFFFB, 16'h0000);

        for (int phase = 0; phase < PHASES; phase++) begin
            // Registers change only with nothing in flight
            drain();
            if (phase < 3) begin
                send_idle = 15;
                recv_idle = 69;
            end else if (phase < 6) begin
                send_idle = 69;
                recv_idle = 15;
            end else begin
                send_idle = 0;
                recv_idle = 0;
            end

            bw = 16'($urandom);
            gain = $urandom;
            yo = 16'($urandom);
            zo = 16'($urandom);
            case (phase)
                0: begin
                    bw = 16'h0000;                     // accelerometer only
                    yo = 16'h7FFF;
                    zo = 16'h8000;
                end
                1: begin
                    bw = 16'hFFFF;                     // gyro path dominates
                    gain = 32'hFFFF_FFFF;
                    yo = 16'h0000;
                    zo = 16'h0000;
                end
                2: begin
                    gain = 32'h0000_0000;
                    yo = 16'h8000;
                    zo = 16'h7FFF;
                end
                3: begin
                    bw = tcf_pkg::BLEND_WEIGHT_RST;
                    gain = tcf_pkg::GYRO_STEP_GAIN_RST;
                    yo = 16'h0000;
                    zo = 16'h0000;
                end
                5: begin
                    bw = 16'hFFFF;
                    gain = 32'($urandom_range(2000000));
                end
                7: bw = 16'h8000;
                default: ;
            endcase
            program_regs(bw, gain, yo, zo);

            for (int n = 0; n < PHASE_ITEMS; n++) begin
                // Pause the sender once mid-phase until the output side is empty
                if (phase == 4 && n == PHASE_ITEMS / 2)
                    drain();
                kind = $urandom_range(9);
                ay = 16'($urandom);
                az = 16'($urandom);
                gx = 16'($urandom);
                if (kind == 6 || kind == 7) begin
                    // near the origin, where the quadrant branches meet
                    ay = {{8{ay[7]}}, ay[7:0]};
                    az = {{8{az[7]}}, az[7:0]};
                end else if (kind >= 8) begin
                    // hold the gyro at an extreme to drive the estimate into saturation
                    gx = phase[0] ? 16'h8000 : 16'h7FFF;
                end
                push_sample(ay, az, gx);
            end
        end

        drain();
        repeat (END_CYCLES) @(posedge aclk);
        if (sb.errors == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule

@@ filelist.f @@
src/tcf_pkg.sv
src/tcf_datapath.sv
src/tcf_ctrl.sv
src/tilt_complementary_filter.sv
src/tcf_checker.sv
test/tilt_complementary_filter_tb.sv
